### src/mpsa_pkg.sv
// Package for the multi-pattern shift-and matcher: sizes, codes and types.
package mpsa_pkg;

	localparam int WordBits    = 64;
	localparam int StateWords  = 4;
	localparam int AlphabetMax = 8;
	localparam int MaxPatterns = 64;
	localparam int Capacity    = WordBits * StateWords;
	localparam int PosW        = $clog2(Capacity);
	localparam int LenW        = $clog2(Capacity + 1);
	localparam int CntW        = $clog2(MaxPatterns + 1);
	localparam int WordW       = (StateWords > 1) ? $clog2(StateWords) : 1;
	localparam int BitW        = $clog2(WordBits);
	localparam int LetW        = $clog2(AlphabetMax);
	localparam int MaskRows    = StateWords * AlphabetMax;
	localparam int RowW        = $clog2(MaskRows);

	localparam logic [1:0] ModeLoad   = 2'd0;
	localparam logic [1:0] ModeSearch = 2'd1;
	localparam logic [1:0] ModeClear  = 2'd2;

	localparam logic [1:0] StDone    = 2'd0;
	localparam logic [1:0] StMatch   = 2'd1;
	localparam logic [1:0] StFull    = 2'd2;
	localparam logic [1:0] StNoPat   = 2'd3;

	localparam logic [1:0] RegLetters = 2'd0;
	localparam logic [1:0] RegCount   = 2'd1;
	localparam logic [1:0] RegReport  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SHIFT,
		S_SCAN,
		S_EMIT
	} state_t;

	// lookup of a symbol in the configured alphabet; later duplicate wins
	typedef struct packed {
		logic            found;
		logic [LetW-1:0] letter;
	} letter_t;

endpackage

### src/mpsa_alpha.sv
// Alphabet lookup: maps a symbol byte to its letter index.
module mpsa_alpha
	import mpsa_pkg::*;
(
	input  logic [63:0] letters,
	input  logic [3:0]  count,
	input  logic [7:0]  symbol,
	output letter_t     result
);
	logic [3:0] n;

	assign n = (count > 4'(AlphabetMax)) ? 4'(AlphabetMax) : count;

	always_comb begin
		result = '0;
		for (int i = 0; i < AlphabetMax; i++) begin
			if (4'(i) < n && letters[8*i +: 8] == symbol) begin
				result.found  = 1'b1;
				result.letter = LetW'(i);
			end
		end
	end
endmodule

### src/mpsa_scan.sv
// Match scan: lowest set bit of one state word and its clearing.
module mpsa_scan
	import mpsa_pkg::*;
(
	input  logic [WordBits-1:0] hits,
	output logic                any,
	output logic [BitW-1:0]     pos,
	output logic [WordBits-1:0] rest
);
	logic [WordBits-1:0] low;

	assign low  = hits & (~hits + WordBits'(1));
	assign any  = |hits;
	assign rest = hits & ~low;

	always_comb begin
		pos = '0;
		for (int b = 0; b < WordBits; b++) begin
			if (low[b]) pos = BitW'(b);
		end
	end
endmodule

### src/multi_pattern_shift_and_matcher.sv
// Top level of the multi-pattern shift-and matcher.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  item in  | start & !busy        | mode, symbol, pattern_end, text_index
//  result   | strobe (one cycle)   | status, pat_id, match_index, last
//  config   | cfg_valid&cfg_ready  | cfg_index, cfg_data
//
// A load, clear, empty search or search on a letter outside the alphabet passes S_LOAD
// only. A search that runs the update then steps through S_SHIFT word by word through
// one shared word unit; with reporting on it then scans each state word in S_SCAN and,
// per reported match, passes S_EMIT (encoder) and rescans the word.
// busy drops in the cycle the last result is strobed.
// Reset clears all marks, masks, the match vector and counters;
// the owner id memory is not cleared. Results cannot be stalled.
module multi_pattern_shift_and_matcher
	import mpsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  symbol,
	input  logic        pattern_end,
	input  logic [31:0] text_index,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [5:0]  pat_id,
	output logic [31:0] match_index,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	// configuration
	logic [63:0] letters_q;
	logic [3:0]  count_q;
	logic        report_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letters_q <= 64'd1413956417;
			count_q   <= 4'd4;
			report_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegLetters: letters_q <= cfg_data;
				RegCount:   count_q   <= cfg_data[3:0];
				RegReport:  report_q  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// latched item
	logic [1:0]  mode_q;
	logic [7:0]  symbol_q;
	logic        pend_q;
	logic [31:0] tix_q;

	// pattern store
	logic [WordBits-1:0] masks_q  [MaskRows];
	logic [WordBits-1:0] starts_q [StateWords];
	logic [WordBits-1:0] ends_q   [StateWords];
	logic [WordBits-1:0] d_q      [StateWords];
	logic [5:0]          owner_mem [Capacity];
	logic [LenW-1:0]     total_q;
	logic [CntW-1:0]     pcount_q;
	logic                at_start_q;

	// sequencer
	state_t          state_q, state_d;
	logic [WordW-1:0] w_q;
	logic            carry_q;
	logic [WordBits-1:0] hits_q;
	letter_t         let_q;
	logic [6:0]      nres_q;
	logic            pend_emit_q;

	letter_t lk;
	mpsa_alpha u_alpha (
		.letters(letters_q), .count(count_q), .symbol(symbol_q), .result(lk)
	);

	logic                scan_any;
	logic [BitW-1:0]     scan_pos;
	logic [WordBits-1:0] scan_rest;
	mpsa_scan u_scan (.hits(hits_q), .any(scan_any), .pos(scan_pos), .rest(scan_rest));

	logic full;
	logic go_search;
	logic [WordW-1:0] lw;
	logic [BitW-1:0]  lb;
	logic [RowW-1:0]  lrow, srow;
	logic [WordBits-1:0] word_new;
	logic last_word;

	assign full = (total_q >= LenW'(Capacity)) || (pcount_q >= CntW'(MaxPatterns));
	// search that runs the word update
	assign go_search = (mode_q == ModeSearch) && (total_q != '0) && lk.found;
	assign lw   = WordW'(total_q >> BitW);
	assign lb   = total_q[BitW-1:0];
	assign lrow = RowW'(lw * AlphabetMax + lk.letter);
	assign srow = RowW'(w_q * AlphabetMax + let_q.letter);
	assign word_new = ((d_q[w_q] << 1) | WordBits'(carry_q) | starts_q[w_q]) & masks_q[srow];
	assign last_word = (w_q == WordW'(StateWords - 1));
	assign busy = (state_q != S_IDLE);

	// registered owner read for reporting
	logic [5:0] owner_rd_q;
	logic [31:0] emit_tix_q;

	// next result, registered onto the ports
	logic        strobe_d;
	logic [1:0]  status_d;
	logic [5:0]  pid_d;
	logic [31:0] midx_d;
	logic        last_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_LOAD;
			S_LOAD: begin
				if (go_search)
					state_d = S_SHIFT;
				else
					state_d = S_IDLE;
			end
			S_SHIFT: if (last_word) state_d = report_q ? S_SCAN : S_IDLE;
			S_SCAN:  if (scan_any) state_d = S_EMIT;
			         else if (last_word) state_d = S_IDLE;
			S_EMIT:  state_d = S_SCAN;
			default: state_d = S_IDLE;
		endcase
	end

	// result outputs
	always_comb begin
		strobe_d = 1'b0;
		status_d = StDone;
		pid_d    = '0;
		midx_d   = '0;
		last_d   = 1'b1;
		case (state_q)
			S_LOAD: begin
				strobe_d = !go_search;
				if (mode_q == ModeLoad) begin
					if (full) status_d = StFull;
					else pid_d = 6'(pcount_q);
				end else if (mode_q == ModeSearch && total_q == '0) begin
					status_d = StNoPat;
				end
			end
			S_SHIFT: strobe_d = last_word && !report_q;
			S_SCAN: begin
				if (pend_emit_q) begin
					// a held match goes out once the next hit or the end is known
					strobe_d = scan_any || last_word;
					status_d = StMatch;
					pid_d    = owner_rd_q;
					midx_d   = emit_tix_q;
					last_d   = !scan_any && last_word;
				end else begin
					// done result when the scan ends with nothing found
					strobe_d = !scan_any && last_word && nres_q == '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		status      <= status_d;
		pat_id      <= pid_d;
		match_index <= midx_d;
		last        <= last_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) owner_rd_q <= owner_mem[{w_q, scan_pos}];
		if (state_q == S_IDLE && start) begin
			mode_q <= mode; symbol_q <= symbol; pend_q <= pattern_end; tix_q <= text_index;
		end
		if (state_q == S_LOAD && mode_q == ModeLoad && !full)
			owner_mem[PosW'(total_q)] <= 6'(pcount_q);
		emit_tix_q <= tix_q;
		if (state_q == S_LOAD) let_q <= lk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			pcount_q    <= '0;
			at_start_q  <= 1'b1;
			w_q         <= '0;
			carry_q     <= 1'b0;
			nres_q      <= '0;
			pend_emit_q <= 1'b0;
			hits_q      <= '0;
			for (int i = 0; i < MaskRows; i++) masks_q[i] <= '0;
			for (int i = 0; i < StateWords; i++) begin
				starts_q[i] <= '0; ends_q[i] <= '0; d_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					w_q <= '0; carry_q <= 1'b0; nres_q <= '0; pend_emit_q <= 1'b0;
					if (mode_q == ModeLoad && !full) begin
						if (lk.found)
							masks_q[lrow][lb] <= 1'b1;
						if (at_start_q) starts_q[lw][lb] <= 1'b1;
						if (pend_q) begin
							ends_q[lw][lb] <= 1'b1;
							pcount_q <= pcount_q + CntW'(1);
						end
						total_q    <= total_q + LenW'(1);
						at_start_q <= pend_q;
					end
					if (mode_q == ModeClear ||
					    (mode_q == ModeSearch && total_q != '0 && !lk.found)) begin
						for (int i = 0; i < StateWords; i++) d_q[i] <= '0;
					end
				end
				S_SHIFT: begin
					d_q[w_q] <= word_new;
					carry_q  <= d_q[w_q][WordBits-1];
					if (last_word) begin
						w_q    <= '0;
						hits_q <= (StateWords == 1) ? (word_new & ends_q[0])
						                            : (d_q[0] & ends_q[0]);
					end else begin
						w_q <= w_q + WordW'(1);
					end
				end
				S_SCAN: begin
					// a held match stays held across empty words
					if (scan_any || last_word) pend_emit_q <= 1'b0;
					if (!scan_any && !last_word) begin
						w_q    <= w_q + WordW'(1);
						hits_q <= d_q[w_q + WordW'(1)] & ends_q[w_q + WordW'(1)];
					end
				end
				S_EMIT: begin
					hits_q      <= scan_rest;
					pend_emit_q <= 1'b1;
					nres_q      <= nres_q + 7'd1;
				end
				default: ;
			endcase
		end
	end
endmodule
